FILE: hw/rtl/fir_pkg.sv
// fir_pkg: shared types and fixed widths of the fir low-pass filter
// no dependencies; imported by fir_lowpass_filter_top

package fir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int TAPS_W   = 7;
    localparam int SHIFT_W  = 5;
    localparam int TIDX_W   = 6;
    localparam int CFG_W    = 7;
    localparam int OUT_MAX  = 32767;
    localparam int OUT_MIN  = -32768;

    localparam logic [TAPS_W-1:0]  TAPS_RESET  = 7'd16;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd17;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_COEF   = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic {
        REG_TAPS  = 1'b0,
        REG_SHIFT = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_MAC,
        S_DRAIN,
        S_SHIFT,
        S_OUT
    } t_state;

endpackage

FILE: hw/rtl/fir_ram.sv
// fir_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies

module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/fir_lowpass_filter_top.sv
// fir_lowpass_filter_top: direct-form fir filter, delay line and coefficients in ram
// depends on fir_pkg and fir_ram
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one item: i_mode selects
//   filter a sample, write a coefficient, or clear the delay line.
//   Output channel (o_out_valid / i_out_stall) returns one filtered sample and
//   a clip flag for each sample item; other items return nothing.
//   Configuration is a plain write port: index 0 taps in use, index 1 output
//   shift; it is to be written while the block is idle, which the block itself does not enforce.
//   Operation: a sample item runs the single shared multiply-accumulate over
//   n taps, n the taps in use (clamped to 1..MAX_TAPS), reading one tap per
//   cycle from the two rams. A coefficient write goes to the coefficient ram
//   as the item is taken; a clear zeroes the delay line one entry per cycle.
//   After reset both rams are zeroed entry by entry, while o_in_stall is
//   high; configuration writes are taken throughout.
//   The result sits in an output register; while the receiver stalls it holds,
//   and new items are still accepted until a second result is ready.

module fir_lowpass_filter_top
    import fir_pkg::*;
#(
    parameter int MAX_TAPS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_mode,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [TIDX_W-1:0]         i_tap_index,
    input  logic signed [COEF_W-1:0]  i_tap_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_filtered,
    output logic                      o_clipped
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

    t_state r_state, n_state;

    logic [TAPS_W-1:0]  r_taps_in_use;
    logic [SHIFT_W-1:0] r_out_shift;

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_last, n_last;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic          r_v1, n_v1;
    logic          r_v2, n_v2;
    logic          r_out_valid, n_out_valid;

    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [ACC_W-1:0]   r_shifted;
    logic signed [SAMPLE_W-1:0] r_filtered, n_filtered;
    logic                      r_clipped, n_clipped;
    logic                      out_load;

    logic                dl_we, cf_we;
    logic [AW-1:0]       dl_waddr, cf_waddr;
    logic [SAMPLE_W-1:0] dl_wdata, dl_rdata;
    logic [COEF_W-1:0]   cf_wdata, cf_rdata;

    logic          in_acc;
    logic [AW-1:0] head_new;
    logic [CW-1:0] taps_eff;

    fir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (dl_waddr),
        .i_wdata (dl_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (dl_rdata)
    );

    fir_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (cf_we),
        .i_waddr (cf_waddr),
        .i_wdata (cf_wdata),
        .i_raddr (r_idx),
        .o_rdata (cf_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign head_new   = (r_head == '0) ? LAST_ADDR : r_head - AW'(1);

    always_comb begin
        if (r_taps_in_use == '0) begin
            taps_eff = CW'(1);
        end else if (32'(r_taps_in_use) > MAX_TAPS) begin
            taps_eff = CW'(MAX_TAPS);
        end else begin
            taps_eff = CW'(r_taps_in_use);
        end
    end

    // next state, ram write ports and datapath control
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_last      = r_last;
        n_rd_addr   = r_rd_addr;
        n_v1        = 1'b0;
        n_v2        = r_v1;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_out_stall;
        n_filtered  = r_filtered;
        n_clipped   = r_clipped;
        out_load    = 1'b0;
        dl_we       = 1'b0;
        dl_waddr    = r_cnt;
        dl_wdata    = '0;
        cf_we       = 1'b0;
        cf_waddr    = r_cnt;
        cf_wdata    = '0;

        if (r_v2) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end

        case (r_state)
            S_INIT: begin
                dl_we = 1'b1;
                cf_we = 1'b1;
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (t_mode'(i_mode))
                        MODE_SAMPLE: begin
                            dl_we     = 1'b1;
                            dl_waddr  = head_new;
                            dl_wdata  = i_sample;
                            n_head    = head_new;
                            n_rd_addr = head_new;
                            n_idx     = '0;
                            n_last    = AW'(taps_eff - CW'(1));
                            n_acc     = '0;
                            n_state   = S_MAC;
                        end
                        MODE_COEF: begin
                            cf_we    = (32'(i_tap_index) < MAX_TAPS);
                            cf_waddr = AW'(i_tap_index);
                            cf_wdata = i_tap_value;
                        end
                        MODE_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                dl_we = 1'b1;
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_MAC: begin
                n_v1      = 1'b1;
                n_idx     = r_idx + AW'(1);
                n_rd_addr = (r_rd_addr == LAST_ADDR) ? '0 : r_rd_addr + AW'(1);
                if (r_idx == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_shifted > SAT_HI) begin
                        n_filtered = SAMPLE_W'(OUT_MAX);
                        n_clipped  = 1'b1;
                    end else if (r_shifted < SAT_LO) begin
                        n_filtered = SAMPLE_W'(OUT_MIN);
                        n_clipped  = 1'b1;
                    end else begin
                        n_filtered = r_shifted[SAMPLE_W-1:0];
                        n_clipped  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_taps_in_use <= TAPS_RESET;
            r_out_shift   <= SHIFT_RESET;
            r_head        <= '0;
            r_cnt         <= '0;
            r_idx         <= '0;
            r_last        <= '0;
            r_rd_addr     <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_last      <= n_last;
            r_rd_addr   <= n_rd_addr;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_index))
                    REG_TAPS:  r_taps_in_use <= i_cfg_data[TAPS_W-1:0];
                    REG_SHIFT: r_out_shift   <= i_cfg_data[SHIFT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= PROD_W'($signed(dl_rdata)) * PROD_W'($signed(cf_rdata));
        end
        r_acc <= n_acc;
        if (r_state == S_SHIFT) begin
            r_shifted <= r_acc >>> r_out_shift;
        end
        if (out_load) begin
            r_filtered <= n_filtered;
            r_clipped  <= n_clipped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_clipped   = r_clipped;

`ifndef SYNTHESIS
    a_prod_follows_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("product stage valid without a preceding read");

    a_idx_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_idx <= r_last))
        else $error("tap index past the last tap in use");

    a_sample_starts_mac : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == MODE_SAMPLE) |=> (r_state == S_MAC))
        else $error("sample item did not start the multiply-accumulate");

    a_hold_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result overwritten while the receiver stalls");
`endif

endmodule
